/* hw/rtl/sdbc_pkg.sv */
// ============================================================================
// sdbc_pkg
// Shared constants and types for the sample DMA buffer cache.
// ============================================================================
package sdbc_pkg;

	localparam int BUFFER_COUNT = 32;
	localparam int BUFFER_WORDS = 512;
	localparam int IDX_W = $clog2(BUFFER_COUNT);
	localparam int CNT_W = $clog2(BUFFER_COUNT + 1);
	localparam int WORD_SHIFT = $clog2(BUFFER_WORDS);

	localparam logic [15:0] LOCAL_BASE_RST = 16'hC000;
	localparam logic [7:0] AGE_LIMIT_RST = 8'd2;

	localparam logic CFG_LOCAL_BASE = 1'b0;
	localparam logic CFG_AGE_LIMIT = 1'b1;

	localparam logic MODE_FETCH = 1'b0;
	localparam logic MODE_CLEAN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_RD,
		ST_F_CMP,
		ST_F_MISS,
		ST_F_SHIFT,
		ST_C_RD,
		ST_C_CMP,
		ST_C_FSHIFT,
		ST_OUT
	} sdbc_state_t;

	typedef struct packed {
		logic load;
		logic pos_clr;
		logic pos_inc;
		logic rd_used;
		logic hit;
		logic miss_fail;
		logic alloc;
		logic ins_step;
		logic ins_done;
		logic clean_keep;
		logic clean_free;
		logic fshift_step;
		logic fshift_done;
		logic clean_done;
		logic out_load;
	} sdbc_cmd_t;

	typedef struct packed {
		logic mode;
		logic walk_end;
		logic start_gt;
		logic win_ok;
		logic no_free;
		logic ins_end;
		logic stale;
		logic fshift_end;
	} sdbc_sts_t;

endpackage

/* hw/rtl/sdbc_ctrl.sv */
// ============================================================================
// sdbc_ctrl
// Sequencer: walks the used list, inserts on a miss, sweeps on a clean.
// ============================================================================
module sdbc_ctrl import sdbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  sdbc_sts_t   sts,
	output sdbc_cmd_t   cmd
);

	sdbc_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.pos_clr = 1'b1;
					state_d = sts.mode ? ST_C_RD : ST_F_RD;
				end
			end
			ST_F_RD: begin
				if (sts.walk_end) begin
					state_d = ST_F_MISS;
				end else begin
					cmd.rd_used = 1'b1;
					state_d = ST_F_CMP;
				end
			end
			ST_F_CMP: begin
				if (sts.start_gt) begin
					state_d = ST_F_MISS;
				end else if (sts.win_ok) begin
					cmd.hit = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.pos_inc = 1'b1;
					state_d = ST_F_RD;
				end
			end
			ST_F_MISS: begin
				if (sts.no_free) begin
					cmd.miss_fail = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.alloc = 1'b1;
					state_d = ST_F_SHIFT;
				end
			end
			ST_F_SHIFT: begin
				if (sts.ins_end) begin
					cmd.ins_done = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.ins_step = 1'b1;
				end
			end
			ST_C_RD: begin
				if (sts.walk_end) begin
					cmd.clean_done = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.rd_used = 1'b1;
					state_d = ST_C_CMP;
				end
			end
			ST_C_CMP: begin
				if (sts.stale) begin
					cmd.clean_free = 1'b1;
					state_d = ST_C_FSHIFT;
				end else begin
					cmd.clean_keep = 1'b1;
					state_d = ST_C_RD;
				end
			end
			ST_C_FSHIFT: begin
				if (sts.fshift_end) begin
					cmd.fshift_done = 1'b1;
					state_d = ST_C_RD;
				end else begin
					cmd.fshift_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/sdbc_datapath.sv */
// ============================================================================
// sdbc_datapath
// Buffer tables, used and free lists, window compare and result register.
// ============================================================================
module sdbc_datapath import sdbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        mode,
	input  logic [31:0] src_addr,
	input  logic [15:0] req_len,
	input  logic [15:0] frame_now,
	input  sdbc_cmd_t   cmd,
	output sdbc_sts_t   sts,
	output logic [15:0] local_addr,
	output logic        was_hit,
	output logic        dma_go,
	output logic [31:0] dma_src,
	output logic        status,
	output logic [6:0]  freed_count
);

	logic [15:0] local_base_q;
	logic [7:0]  age_limit_q;
	logic        mode_q;
	logic [31:0] addr_q;
	logic [15:0] len_q, frame_q;

	// Small register files; the used list is shifted during insertion.
	logic [31:0]      start_q [BUFFER_COUNT];
	logic [15:0]      last_q  [BUFFER_COUNT];
	logic [IDX_W-1:0] used_q  [BUFFER_COUNT];
	logic [IDX_W-1:0] free_q  [BUFFER_COUNT];
	logic [CNT_W-1:0] used_cnt_q, free_cnt_q;

	logic [CNT_W-1:0] pos_q, wr_q, ptr_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      st_q;
	logic [15:0]      lu_q;
	logic [6:0]       freed_q;
	logic [15:0] r_la; logic r_hit, r_go, r_st; logic [31:0] r_src;

	logic [32:0] want_end, win_end;
	logic [16:0] age_sum;
	logic [15:0] buf_local;
	logic [IDX_W-1:0] new_idx;

	assign want_end = {1'b0, addr_q} + {17'd0, len_q};
	assign win_end = {1'b0, st_q} + 33'(BUFFER_WORDS);
	assign age_sum = {1'b0, lu_q} + {9'd0, age_limit_q};
	assign buf_local = local_base_q + 16'({idx_q, {WORD_SHIFT{1'b0}}});
	assign new_idx = free_q[0];

	assign sts.mode = mode;
	assign sts.walk_end = (pos_q >= used_cnt_q);
	assign sts.start_gt = (st_q > addr_q);
	assign sts.win_ok = (want_end <= win_end);
	assign sts.no_free = (free_cnt_q == '0) || (used_cnt_q >= CNT_W'(BUFFER_COUNT));
	assign sts.ins_end = (ptr_q <= pos_q);
	assign sts.stale = (age_sum < {1'b0, frame_q}) && (free_cnt_q < CNT_W'(BUFFER_COUNT));
	assign sts.fshift_end = (ptr_q <= CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_base_q <= LOCAL_BASE_RST;
			age_limit_q <= AGE_LIMIT_RST;
			used_cnt_q <= '0;
			free_cnt_q <= CNT_W'(BUFFER_COUNT);
			for (int i = 0; i < BUFFER_COUNT; i++) free_q[i] <= IDX_W'(i);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LOCAL_BASE: local_base_q <= cfg_data;
					CFG_AGE_LIMIT:  age_limit_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.alloc) begin
				for (int i = 0; i < BUFFER_COUNT - 1; i++) free_q[i] <= free_q[i+1];
				free_cnt_q <= free_cnt_q - 1'b1;
			end
			if (cmd.ins_done) used_cnt_q <= used_cnt_q + 1'b1;
			if (cmd.ins_step) used_q[ptr_q[IDX_W-1:0]] <= used_q[ptr_q[IDX_W-1:0] - 1'b1];
			if (cmd.ins_done) used_q[pos_q[IDX_W-1:0]] <= idx_q;
			if (cmd.clean_keep) used_q[wr_q[IDX_W-1:0]] <= idx_q;
			if (cmd.clean_free) free_cnt_q <= free_cnt_q + 1'b1;
			if (cmd.fshift_step) free_q[ptr_q[IDX_W-1:0]] <= free_q[ptr_q[IDX_W-1:0] - 1'b1];
			if (cmd.clean_free && free_cnt_q == '0) free_q[0] <= idx_q;
			// A freed buffer goes in second place unless it is the only free one.
			if (cmd.fshift_done && free_cnt_q > CNT_W'(1)) free_q[1] <= idx_q;
			if (cmd.clean_done) used_cnt_q <= wr_q;
		end
	end

	// Walk and sequencing registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode; addr_q <= src_addr; len_q <= req_len; frame_q <= frame_now;
			wr_q <= '0; freed_q <= '0;
		end
		if (cmd.pos_clr) pos_q <= '0;
		if (cmd.pos_inc) pos_q <= pos_q + 1'b1;
		if (cmd.rd_used) begin
			idx_q <= used_q[pos_q[IDX_W-1:0]];
			st_q <= start_q[used_q[pos_q[IDX_W-1:0]]];
			lu_q <= last_q[used_q[pos_q[IDX_W-1:0]]];
		end
		if (cmd.hit) begin
			last_q[idx_q] <= frame_q;
			r_la <= buf_local + addr_q[15:0] - st_q[15:0];
			r_hit <= 1'b1; r_go <= 1'b0; r_src <= '0; r_st <= 1'b0;
		end
		if (cmd.miss_fail) begin
			r_la <= '0; r_hit <= 1'b0; r_go <= 1'b0; r_src <= '0; r_st <= 1'b1;
		end
		if (cmd.alloc) begin
			idx_q <= new_idx;
			ptr_q <= used_cnt_q;
			start_q[new_idx] <= {addr_q[31:1], 1'b0};
			last_q[new_idx] <= frame_q;
			r_la <= local_base_q + 16'({new_idx, {WORD_SHIFT{1'b0}}}) + {15'd0, addr_q[0]};
			r_hit <= 1'b0; r_go <= 1'b1; r_src <= {addr_q[31:1], 1'b0}; r_st <= 1'b0;
		end
		if (cmd.ins_step) ptr_q <= ptr_q - 1'b1;
		if (cmd.clean_keep) begin
			wr_q <= wr_q + 1'b1; pos_q <= pos_q + 1'b1;
		end
		if (cmd.clean_free) begin
			freed_q <= freed_q + 1'b1; pos_q <= pos_q + 1'b1; ptr_q <= free_cnt_q;
		end
		if (cmd.fshift_step) ptr_q <= ptr_q - 1'b1;
		if (cmd.clean_done) begin
			r_la <= '0; r_hit <= 1'b0; r_go <= 1'b0; r_src <= '0; r_st <= 1'b0;
		end
		if (cmd.out_load) begin
			local_addr <= r_la; was_hit <= r_hit; dma_go <= r_go; dma_src <= r_src;
			status <= r_st; freed_count <= mode_q ? freed_q : 7'd0;
		end
	end

endmodule

/* hw/rtl/sample_dma_buffer_cache_unit.sv */
// ============================================================================
// sample_dma_buffer_cache_unit
// Buffer pool cache for sample memory with sorted used list and DMA fill.
// ============================================================================
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | mode, src_addr, req_len, frame_now
//  out     | output    | out_valid/out_stall| local_addr .. freed_count
//
// A fetch reads and compares each used buffer in turn and ends on a hit; on
// a miss it takes a free buffer and shifts the used list to insert it, or
// reports failure when no buffer is free or the used list is full.
// A clean reads and compares each used buffer and, for each freed buffer,
// shifts the free list to place it. One item is in work at a time; reset
// empties the used list and fills the free list at once. A stalled result
// holds in its register.
module sample_dma_buffer_cache_unit import sdbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] src_addr,
	input  logic [15:0] req_len,
	input  logic [15:0] frame_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] local_addr,
	output logic        was_hit,
	output logic        dma_go,
	output logic [31:0] dma_src,
	output logic        status,
	output logic [6:0]  freed_count
);

	sdbc_cmd_t cmd;
	sdbc_sts_t sts;

	sdbc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	sdbc_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .mode, .src_addr, .req_len,
		.frame_now, .cmd, .sts, .local_addr, .was_hit, .dma_go, .dma_src, .status,
		.freed_count
	);

endmodule

/* hw/rtl/sdbc_checker.sv */
// ============================================================================
// sdbc_checker
// Port level checks for the buffer cache.
// ============================================================================
module sdbc_checker (
	input logic clk, arst_n, in_valid, out_valid, out_stall, in_stall, was_hit, dma_go,
	input logic status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_hit_go: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_hit && dma_go)) else $error("hit with dma");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !dma_go && !was_hit) else $error("bad fail result");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second beat taken while busy");
endmodule

bind sample_dma_buffer_cache_unit sdbc_checker u_chk (.*);

/* bench/tb_sample_dma_buffer_cache_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for sample_dma_buffer_cache_unit
// Drives fetch and clean beats into the buffer cache under random gaps and
// output stalls. It predicts each result from its own model of the buffer pool
// and compares every field of each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sample_dma_buffer_cache_unit;
	import sdbc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_LOCAL_BASE;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = MODE_FETCH;
	logic [31:0] src_addr = '0;
	logic [15:0] req_len = '0;
	logic [15:0] frame_now = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] local_addr;
	logic        was_hit;
	logic        dma_go;
	logic [31:0] dma_src;
	logic        status;
	logic [6:0]  freed_count;

	sample_dma_buffer_cache_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One predicted output beat.
	typedef struct packed {
		logic [15:0] local_addr;
		logic        was_hit;
		logic        dma_go;
		logic [31:0] dma_src;
		logic        status;
		logic [6:0]  freed_count;
	} cache_answer_t;

	cache_answer_t pending_answers[$];
	bit            had_error = 0;
	bit            stall_enable = 1;
	int            stall_left = 0;

	// Shadow copy of the buffer pool.
	logic [15:0] base_reg;
	logic [7:0]  age_reg;
	logic [31:0] start_of[BUFFER_COUNT];
	logic [15:0] used_at[BUFFER_COUNT];
	int          used_order[BUFFER_COUNT];
	int          n_used;
	int          free_order[BUFFER_COUNT];
	int          n_free;

	// Frame counter tracked by the stimulus so that ages stay meaningful.
	logic [15:0] frame_cur;

	function automatic logic [15:0] buffer_addr(int idx);
		return base_reg + 16'(idx * BUFFER_WORDS);
	endfunction

	function automatic cache_answer_t pool_fetch(logic [31:0] addr, logic [15:0] len,
			logic [15:0] frame);
		cache_answer_t r;
		logic [32:0]   want_end;
		int            pos, idx;
		r = '0;
		want_end = {1'b0, addr} + len;
		pos = 0;
		while (pos < n_used) begin
			idx = used_order[pos];
			if (start_of[idx] > addr)
				break;
			if (want_end <= {1'b0, start_of[idx]} + BUFFER_WORDS) begin
				used_at[idx] = frame;
				r.local_addr = buffer_addr(idx) + 16'(addr - start_of[idx]);
				r.was_hit = 1'b1;
				return r;
			end
			pos++;
		end
		if (n_free == 0 || n_used >= BUFFER_COUNT) begin
			r.status = 1'b1;
			return r;
		end
		idx = free_order[0];
		for (int i = 1; i < n_free; i++)
			free_order[i - 1] = free_order[i];
		n_free--;
		for (int i = n_used; i > pos; i--)
			used_order[i] = used_order[i - 1];
		used_order[pos] = idx;
		n_used++;
		start_of[idx] = {addr[31:1], 1'b0};
		used_at[idx] = frame;
		r.local_addr = buffer_addr(idx) + 16'(addr[0]);
		r.dma_go = 1'b1;
		r.dma_src = start_of[idx];
		return r;
	endfunction

	function automatic cache_answer_t pool_clean(logic [15:0] frame);
		cache_answer_t r;
		int            keep, idx;
		r = '0;
		keep = 0;
		for (int rd = 0; rd < n_used; rd++) begin
			idx = used_order[rd];
			if (({1'b0, used_at[idx]} + age_reg) < {1'b0, frame} && n_free < BUFFER_COUNT) begin
				if (n_free == 0)
					free_order[0] = idx;
				else begin
					for (int i = n_free; i > 1; i--)
						free_order[i] = free_order[i - 1];
					free_order[1] = idx;
				end
				n_free++;
				r.freed_count++;
			end else begin
				used_order[keep++] = idx;
			end
		end
		n_used = keep;
		return r;
	endfunction

	// Sends one beat and records its prediction at the accepting edge.
	// Valid stays high into a back-to-back beat; drain lowers it at the end.
	task automatic send_beat(logic m, logic [31:0] a, logic [15:0] l, logic [15:0] f);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0)
			in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
		in_valid  <= 1'b1;
		mode      <= m;
		src_addr  <= a;
		req_len   <= l;
		frame_now <= f;
		do
			@(posedge clk);
		while (in_stall);
		pending_answers.push_back(m == MODE_CLEAN ? pool_clean(f) : pool_fetch(a, l, f));
	endtask

	task automatic fetch(logic [31:0] a, logic [15:0] l);
		send_beat(MODE_FETCH, a, l, frame_cur);
	endtask

	task automatic clean();
		send_beat(MODE_CLEAN, $urandom, 16'($urandom), frame_cur);
	endtask

	// Waits for every prediction to be met, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LOCAL_BASE)
			base_reg = val;
		else
			age_reg = val[7:0];
		@(posedge clk);
	endtask

	// Edge values of every field, a hit, misses on odd and even addresses,
	// windows that reach past 2^32 and a clean that frees everything.
	task automatic test_directed();
		frame_cur = 16'd10;
		fetch(32'h0000_0000, 16'd0);
		fetch(32'h0000_0001, 16'd511);
		fetch(32'h0000_0010, 16'd100);
		fetch(32'h0000_0001, 16'd512);
		fetch(32'hFFFF_FFFF, 16'hFFFF);
		fetch(32'hFFFF_FFFE, 16'd1);
		fetch(32'hFFFF_FE00, 16'd0);
		fetch(32'h5555_5555, 16'h5555);
		fetch(32'hAAAA_AAAA, 16'hAAAA);
		frame_cur = 16'd12;
		clean();
		frame_cur = 16'd13;
		clean();
		frame_cur = 16'hFFFF;
		clean();
		fetch(32'h1234_5679, 16'd2);
		frame_cur = 16'd0;
		clean();
	endtask

	// Fills the pool completely so that a further miss reports no free buffer,
	// then runs a clean, which frees nothing under the age limit set before it.
	task automatic test_pool_full();
		frame_cur = 16'd100;
		for (int i = 0; i < BUFFER_COUNT + 3; i++)
			fetch(32'(i) * 32'd4096 + 32'($urandom_range(0, 1)), 16'($urandom_range(0, 600)));
		fetch(32'h0000_0002, 16'd4);
		frame_cur = 16'd200;
		clean();
		fetch(32'h0000_0002, 16'd4);
	endtask

	// Random working set: requests cluster in a few regions so hits, misses,
	// overlap and pool exhaustion all happen; cleans advance the frame.
	task automatic test_random(int n);
		logic [31:0] region;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 15) == 0) begin
				frame_cur = frame_cur + 16'($urandom_range(0, 6));
				clean();
			end else begin
				case ($urandom_range(0, 3))
					0: region = $urandom;
					1: region = 32'hFFFF_F000 + $urandom_range(0, 4095);
					default: region = 32'($urandom_range(0, 20)) * 32'd700
						+ $urandom_range(0, 600);
				endcase
				if ($urandom_range(0, 7) == 0)
					frame_cur = frame_cur + 16'd1;
				fetch(region, ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 520)));
			end
		end
	endtask

	// Output side: stall runs that are mostly short and now and then long,
	// with quiet stretches of no stalling.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_enable && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 199) == 0)
			stall_enable <= ~stall_enable;
	end

	// Compares each accepted output beat with the oldest prediction.
	always @(posedge clk) begin
		cache_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("output beat with no prediction waiting");
				had_error = 1;
			end else begin
				want = pending_answers.pop_front();
				if (local_addr !== want.local_addr) begin
					$error("local_addr: expected %h, got %h", want.local_addr, local_addr);
					had_error = 1;
				end
				if (was_hit !== want.was_hit) begin
					$error("was_hit: expected %b, got %b", want.was_hit, was_hit);
					had_error = 1;
				end
				if (dma_go !== want.dma_go) begin
					$error("dma_go: expected %b, got %b", want.dma_go, dma_go);
					had_error = 1;
				end
				if (dma_src !== want.dma_src) begin
					$error("dma_src: expected %h, got %h", want.dma_src, dma_src);
					had_error = 1;
				end
				if (status !== want.status) begin
					$error("status: expected %b, got %b", want.status, status);
					had_error = 1;
				end
				if (freed_count !== want.freed_count) begin
					$error("freed_count: expected %0d, got %0d", want.freed_count, freed_count);
					had_error = 1;
				end
			end
		end
	end

	initial begin
		base_reg = LOCAL_BASE_RST;
		age_reg  = AGE_LIMIT_RST;
		n_used   = 0;
		n_free   = BUFFER_COUNT;
		for (int i = 0; i < BUFFER_COUNT; i++)
			free_order[i] = i;
		frame_cur = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain();
		write_reg(CFG_LOCAL_BASE, 16'hFFFF);
		write_reg(CFG_AGE_LIMIT, 16'h00FF);
		test_pool_full();
		drain();
		write_reg(CFG_LOCAL_BASE, 16'h0000);
		write_reg(CFG_AGE_LIMIT, 16'h0000);
		test_random(400);
		drain();
		write_reg(CFG_LOCAL_BASE, 16'h7E01);
		write_reg(CFG_AGE_LIMIT, 16'hFF03);
		test_random(400);
		drain();
		write_reg(CFG_LOCAL_BASE, 16'($urandom));
		write_reg(CFG_AGE_LIMIT, 16'($urandom_range(0, 255)));
		test_random(350);
		drain();

		if (!had_error)
			$display("PASS sample_dma_buffer_cache_unit");
		else
			$display("FAIL sample_dma_buffer_cache_unit");
		$finish;
	end

	// This limit leaves room for every beat to be a full-pool clean with a long
	// stall and gap.
	initial begin
		#20000000;
		$display("FAIL sample_dma_buffer_cache_unit");
		$finish;
	end

endmodule

/* sample_dma_buffer_cache_unit.f */
hw/rtl/sdbc_pkg.sv
hw/rtl/sdbc_ctrl.sv
hw/rtl/sdbc_datapath.sv
hw/rtl/sample_dma_buffer_cache_unit.sv
hw/rtl/sdbc_checker.sv
bench/tb_sample_dma_buffer_cache_unit.sv
